// ===== rtl/mvsm_pkg.sv =====
package mvsm_pkg;

   localparam int NumVoicesDefault      = 30;
   localparam int SampleMemDepthDefault = 65536;
   localparam int NumTags               = 8;

   localparam int SampleW = 16;
   localparam int AddrInW = 16;
   localparam int LenW    = 17;
   localparam int TagW    = 3;
   localparam int FlagW   = 8;

   // Restoring reduction of a 16-bit address modulo a depth of at least 256
   // needs at most eight quotient bits.
   localparam int RedSteps = 8;
   localparam int RedKW    = 3;

   typedef logic [1:0] op_type;

   localparam op_type OpLoad  = 2'd0;
   localparam op_type OpQueue = 2'd1;
   localparam op_type OpTick  = 2'd2;

   function automatic logic [FlagW-1:0] tag_mask(input logic [TagW-1:0] tag);
      logic [FlagW-1:0] mask;
      mask = '0;
      if (FlagW'(tag) < FlagW'(NumTags)) begin
         mask = FlagW'(1) << tag;
      end
      return mask;
   endfunction

endpackage

// ===== rtl/mvsm_sample_ram.sv =====
module mvsm_sample_ram import mvsm_pkg::*; #(
   parameter int DEPTH = SampleMemDepthDefault,
   parameter int AW    = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [SampleW-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [SampleW-1:0] rd_data
);

   logic signed [SampleW-1:0] mem [DEPTH];
   logic signed [SampleW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multi_voice_sample_mixer_core.sv =====
// Multi-voice sample mixer.
// A request is taken when start is high and busy is low; busy stays high
// until the request's response has been produced. req_op selects the work:
// load writes req_sample_in into the sample memory at req_address, queue
// claims the lowest free voice slot for a sound (req_address, req_sound_length,
// req_sound_tag) and clears that tag's done flag, tick mixes the next sample
// of every active voice into one saturated 16-bit output sample.
// Every request gives exactly one response, shown for one cycle with
// rsp_strobe high; the receiver cannot stall it, so it must sample it then.
// A load runs the address reduction, writes the memory and responds; a queue
// runs the reduction and scans the slots upward to the first free one or the
// last; a tick reads every slot, drains the last read and responds. The voice
// pass visits one slot per cycle through the single sample memory read port,
// and an eight-step shift-subtract unit reduces addresses modulo the memory
// depth. A zero-length queue or an unused op code skips both passes.
// Reset frees all voice slots, clears the done flags and the sequencer; the sample
// memory keeps whatever it held and must be loaded before it is played.
module multi_voice_sample_mixer_core import mvsm_pkg::*; #(
   parameter int NUM_VOICES       = NumVoicesDefault,
   parameter int SAMPLE_MEM_DEPTH = SampleMemDepthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  op_type                    req_op,
   input  logic [AddrInW-1:0]        req_address,
   input  logic signed [SampleW-1:0] req_sample_in,
   input  logic [LenW-1:0]           req_sound_length,
   input  logic [TagW-1:0]           req_sound_tag,
   output logic                      rsp_strobe,
   output logic signed [SampleW-1:0] rsp_mixed_sample,
   output logic                      rsp_sample_valid,
   output logic                      rsp_queue_accepted,
   output logic                      rsp_queue_full,
   output logic [FlagW-1:0]          rsp_done_flags
);

   localparam int AW   = (SAMPLE_MEM_DEPTH > 1) ? $clog2(SAMPLE_MEM_DEPTH) : 1;
   localparam int IW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW   = AW + 9;
   localparam int AccW = 17 + $clog2(NUM_VOICES + 1);

   localparam logic [IW-1:0]          LastIdx = IW'(NUM_VOICES - 1);
   localparam logic signed [AccW-1:0] AccMax  = AccW'(32767);
   localparam logic signed [AccW-1:0] AccMin  = AccW'(-32768);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_TICK   = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [RedKW-1:0]          red_k_ff, red_k_in;
   logic [AddrInW-1:0]        x_ff, x_in;
   op_type                    op_ff, op_in;
   logic signed [SampleW-1:0] smp_ff, smp_in;
   logic [LenW-1:0]           len_ff, len_in;
   logic [TagW-1:0]           tag_ff, tag_in;
   logic                      qacc_ff, qacc_in;
   logic                      qfull_ff, qfull_in;
   logic [FlagW-1:0]          tag_done_ff, tag_done_in;
   logic [NUM_VOICES-1:0]     active_ff, active_in;
   logic                      pend_ff;
   logic signed [AccW-1:0]    acc_ff;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic signed [SampleW-1:0] rsp_mixed_ff, rsp_mixed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_acc_ff, rsp_acc_in;
   logic                      rsp_full_ff, rsp_full_in;
   logic [FlagW-1:0]          rsp_done_ff, rsp_done_in;

   logic [AW-1:0]             voice_ptr_ff [NUM_VOICES];
   logic [LenW-1:0]           voice_pos_ff [NUM_VOICES];
   logic [LenW-1:0]           voice_len_ff [NUM_VOICES];
   logic [TagW-1:0]           voice_tag_ff [NUM_VOICES];

   logic                      v_we;
   logic [AW-1:0]             v_ptr_wd;
   logic [LenW-1:0]           v_pos_wd;
   logic [LenW-1:0]           v_len_wd;
   logic [TagW-1:0]           v_tag_wd;

   logic [CW-1:0]             red_div;
   logic                      red_ge;
   logic [AW-1:0]             red_addr;
   logic [AW:0]               ptr_p1;
   logic [AW-1:0]             ptr_next;
   logic [LenW-1:0]           pos_p1;
   logic                      voice_end;
   logic signed [SampleW-1:0] sat_sample;
   logic                      mem_we;
   logic signed [SampleW-1:0] rd_data;

   mvsm_sample_ram #(
      .DEPTH (SAMPLE_MEM_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (red_addr),
      .wr_data (smp_ff),
      .rd_addr (voice_ptr_ff[idx_ff]),
      .rd_data (rd_data)
   );

   // One shift-subtract step of the address reduction per cycle.
   assign red_div  = CW'(SAMPLE_MEM_DEPTH) << red_k_ff;
   assign red_ge   = CW'(x_ff) >= red_div;
   assign red_addr = AW'(x_ff);

   assign ptr_p1    = {1'b0, voice_ptr_ff[idx_ff]} + (AW + 1)'(1);
   assign ptr_next  = (ptr_p1 == (AW + 1)'(SAMPLE_MEM_DEPTH)) ? '0 : ptr_p1[AW-1:0];
   assign pos_p1    = voice_pos_ff[idx_ff] + LenW'(1);
   assign voice_end = pos_p1 >= voice_len_ff[idx_ff];

   always_comb begin
      if (acc_ff > AccMax) begin
         sat_sample = 16'sh7fff;
      end else if (acc_ff < AccMin) begin
         sat_sample = -16'sh8000;
      end else begin
         sat_sample = SampleW'(acc_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      red_k_in      = red_k_ff;
      x_in          = x_ff;
      op_in         = op_ff;
      smp_in        = smp_ff;
      len_in        = len_ff;
      tag_in        = tag_ff;
      qacc_in       = qacc_ff;
      qfull_in      = qfull_ff;
      tag_done_in   = tag_done_ff;
      active_in     = active_ff;
      rsp_strobe_in = 1'b0;
      rsp_mixed_in  = rsp_mixed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_done_in   = rsp_done_ff;
      v_we          = 1'b0;
      v_ptr_wd      = ptr_next;
      v_pos_wd      = pos_p1;
      v_len_wd      = voice_len_ff[idx_ff];
      v_tag_wd      = voice_tag_ff[idx_ff];
      mem_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               x_in     = req_address;
               smp_in   = req_sample_in;
               len_in   = req_sound_length;
               tag_in   = req_sound_tag;
               idx_in   = '0;
               red_k_in = RedKW'(RedSteps - 1);
               qacc_in  = 1'b0;
               qfull_in = 1'b0;
               unique case (req_op)
                  OpLoad: begin
                     state_in = S_REDUCE;
                  end
                  OpQueue: begin
                     if (req_sound_length == '0) begin
                        qacc_in     = 1'b1;
                        tag_done_in = tag_done_ff | tag_mask(req_sound_tag);
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_REDUCE;
                     end
                  end
                  OpTick: begin
                     state_in = S_TICK;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_REDUCE: begin
            if (red_ge) begin
               x_in = x_ff - AddrInW'(red_div);
            end
            red_k_in = red_k_ff - RedKW'(1);
            if (red_k_ff == '0) begin
               state_in = (op_ff == OpLoad) ? S_WRITE : S_SCAN;
            end
         end
         S_WRITE: begin
            mem_we   = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (!active_ff[idx_ff]) begin
               v_we              = 1'b1;
               v_ptr_wd          = red_addr;
               v_pos_wd          = '0;
               v_len_wd          = len_ff;
               v_tag_wd          = tag_ff;
               active_in[idx_ff] = 1'b1;
               tag_done_in       = tag_done_ff & ~tag_mask(tag_ff);
               qacc_in           = 1'b1;
               state_in          = S_DONE;
            end else if (idx_ff == LastIdx) begin
               qfull_in = 1'b1;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_TICK: begin
            // The memory read for this slot is issued now; its sample comes back from
            // the registered read port and is added to the sum in the next cycle.
            if (active_ff[idx_ff]) begin
               v_we = 1'b1;
               if (voice_end) begin
                  active_in[idx_ff] = 1'b0;
                  v_pos_wd          = '0;
                  tag_done_in       = tag_done_ff | tag_mask(voice_tag_ff[idx_ff]);
               end
            end
            if (idx_ff == LastIdx) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_mixed_in  = (op_ff == OpTick) ? sat_sample : '0;
            rsp_valid_in  = op_ff == OpTick;
            rsp_acc_in    = qacc_ff;
            rsp_full_in   = qfull_ff;
            rsp_done_in   = tag_done_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tag_done_ff   <= '0;
         active_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tag_done_ff   <= tag_done_in;
         active_ff     <= active_in;
         pend_ff       <= (state_ff == S_TICK) && active_ff[idx_ff];
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      red_k_ff     <= red_k_in;
      x_ff         <= x_in;
      op_ff        <= op_in;
      smp_ff       <= smp_in;
      len_ff       <= len_in;
      tag_ff       <= tag_in;
      qacc_ff      <= qacc_in;
      qfull_ff     <= qfull_in;
      rsp_mixed_ff <= rsp_mixed_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_done_ff  <= rsp_done_in;
      if (state_ff == S_IDLE) begin
         acc_ff <= '0;
      end else if (pend_ff) begin
         acc_ff <= acc_ff + AccW'(rd_data);
      end
      if (v_we) begin
         voice_ptr_ff[idx_ff] <= v_ptr_wd;
         voice_pos_ff[idx_ff] <= v_pos_wd;
         voice_len_ff[idx_ff] <= v_len_wd;
         voice_tag_ff[idx_ff] <= v_tag_wd;
      end
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_mixed_sample   = rsp_mixed_ff;
   assign rsp_sample_valid   = rsp_valid_ff;
   assign rsp_queue_accepted = rsp_acc_ff;
   assign rsp_queue_full     = rsp_full_ff;
   assign rsp_done_flags     = rsp_done_ff;

endmodule
